// ===== rtl/core/wls_pkg.sv =====
package wls_pkg;

  localparam int unsigned TIME_W = 64;
  localparam int unsigned DUR_W  = 32;
  localparam int unsigned WIN_W  = 32;

  // tuser of the request channel
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // configuration register indexes
  localparam logic CFG_LONG_WINDOW  = 1'b0;
  localparam logic CFG_SHORT_WINDOW = 1'b1;

  localparam logic [WIN_W-1:0] LONG_WINDOW_RST  = 32'd10_000_000;
  localparam logic [WIN_W-1:0] SHORT_WINDOW_RST = 32'd1_000_000;

  localparam int unsigned IN_DATA_W  = 2 * TIME_W + DUR_W;
  localparam int unsigned OUT_DATA_W = 3 * DUR_W;
  localparam int unsigned OUT_USER_W = 2;

endpackage

// ===== rtl/core/wls_ram.sv =====
module wls_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/wls_div.sv =====
// Restoring divider, one quotient bit per cycle.
module wls_div #(
  parameter int unsigned N = 43,
  parameter int unsigned D = 12
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [N-1:0] dividend_i,
  input  logic [D-1:0] divisor_i,
  output logic         done_o,
  output logic [N-1:0] quotient_o
);

  localparam int unsigned CYC_W = $clog2(N + 1);

  logic [CYC_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [N-1:0]     quo_q, quo_d;
  logic [D-1:0]     rem_q, rem_d;
  logic [D-1:0]     dsr_q, dsr_d;
  logic [D:0]       shifted;
  logic [D+1:0]     diff;

  assign shifted = {rem_q, quo_q[N-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr_q};

  always_comb begin
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d = CYC_W'(N);
      quo_d = dividend_i;
      rem_d = '0;
      dsr_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - CYC_W'(1);
      done_d = (cnt_q == CYC_W'(1));
      if (diff[D+1]) begin
        rem_d = shifted[D-1:0];
        quo_d = {quo_q[N-2:0], 1'b0};
      end else begin
        rem_d = diff[D-1:0];
        quo_d = {quo_q[N-2:0], 1'b1};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/core/windowed_latency_statistics_core.sv =====
// Windowed latency statistics. Add requests (tuser 0) store a timestamp and a duration in
// a ring of RING_DEPTH entries held in one single-port-read RAM, one add per cycle,
// back to back while no query runs, overwriting the oldest entry once the ring is full. A
// query request (tuser 1) scans the filled part of the ring through the RAM read port, one
// entry per cycle, and then runs the long and the short mean through one shared bit-serial
// divider. The time from a query's request to its result is set by the ring scan and the
// divider; the scan covers the entries written since reset, at most RING_DEPTH. The result
// sits in an output register, so a new request is taken while it waits. Window registers
// may be written only while no query is running. Slots are tracked with a fill count, so
// no clearing pass follows reset.
module windowed_latency_statistics_core #(
  parameter int unsigned RING_DEPTH = 2048
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request: [63:0] sample_time, [95:64] sample_duration, [159:96] query_time
  input  logic [wls_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // request: [0] req_type
  input  logic [0:0]                     s_axis_tuser_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // result: [31:0] short_average_us, [63:32] long_average_us, [95:64] long_maximum_us
  output logic [wls_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // result: [0] short_valid, [1] long_valid
  output logic [wls_pkg::OUT_USER_W-1:0] m_axis_tuser_o,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  input  logic                           cfg_we_i,
  input  logic                           cfg_index_i,
  input  logic [wls_pkg::WIN_W-1:0]      cfg_wdata_i
);

  localparam int unsigned ADDR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int unsigned SUM_W  = ADDR_W + wls_pkg::DUR_W;
  localparam int unsigned ENT_W  = wls_pkg::TIME_W + wls_pkg::DUR_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV_LONG,
    ST_DIV_SHORT,
    ST_RESULT
  } state_e;

  state_e state_q;

  logic [wls_pkg::WIN_W-1:0] long_win_q, short_win_q;
  logic [ADDR_W-1:0]         wp_q;
  logic [CNT_W-1:0]          fill_q;
  logic [CNT_W-1:0]          rd_idx_q;
  logic [wls_pkg::TIME_W-1:0] now_q;

  logic s_acc, add_acc, query_acc;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_acc     = s_axis_tvalid_i && s_axis_tready_o;
  assign add_acc   = s_acc && (s_axis_tuser_i[0] == wls_pkg::REQ_ADD);
  assign query_acc = s_acc && (s_axis_tuser_i[0] == wls_pkg::REQ_QUERY);

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_win_q  <= wls_pkg::LONG_WINDOW_RST;
      short_win_q <= wls_pkg::SHORT_WINDOW_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        wls_pkg::CFG_LONG_WINDOW:  long_win_q  <= cfg_wdata_i;
        wls_pkg::CFG_SHORT_WINDOW: short_win_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ring write side; entries below fill_q have been written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
    end else if (add_acc) begin
      wp_q <= (wp_q == ADDR_W'(RING_DEPTH - 1)) ? '0 : wp_q + ADDR_W'(1);
      if (fill_q != CNT_W'(RING_DEPTH)) begin
        fill_q <= fill_q + CNT_W'(1);
      end
    end
  end

  logic             rd_en;
  logic [ENT_W-1:0] rd_data;

  assign rd_en = (state_q == ST_SCAN) && (rd_idx_q < fill_q);

  wls_ram #(
    .WIDTH(ENT_W),
    .DEPTH(RING_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (add_acc),
    .waddr_i(wp_q),
    .wdata_i(s_axis_tdata_i[ENT_W-1:0]),
    .re_i   (rd_en),
    .raddr_i(rd_idx_q[ADDR_W-1:0]),
    .rdata_o(rd_data)
  );

  // scan pipeline: read, classify, accumulate
  logic rd_vld_q, s2_vld_q, s2_long_q, s2_short_q;
  logic [wls_pkg::DUR_W-1:0]  s2_dur_q;
  logic [wls_pkg::TIME_W-1:0] rd_time, age;
  logic                       in_long, in_short;

  assign rd_time  = rd_data[wls_pkg::TIME_W-1:0];
  assign age      = now_q - rd_time;
  assign in_long  = (rd_time <= now_q) && (age <= {32'd0, long_win_q});
  assign in_short = in_long && (age <= {32'd0, short_win_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0;
      rd_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      if (query_acc) begin
        rd_idx_q <= '0;
      end else if (rd_en) begin
        rd_idx_q <= rd_idx_q + CNT_W'(1);
      end
      rd_vld_q <= rd_en;
      s2_vld_q <= rd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (query_acc) begin
      now_q <= s_axis_tdata_i[wls_pkg::IN_DATA_W-1:ENT_W];
    end
    s2_long_q  <= in_long;
    s2_short_q <= in_short;
    s2_dur_q   <= rd_data[ENT_W-1:wls_pkg::TIME_W];
  end

  logic [SUM_W-1:0]          long_sum_q, short_sum_q;
  logic [CNT_W-1:0]          long_cnt_q, short_cnt_q;
  logic [wls_pkg::DUR_W-1:0] long_max_q;

  always_ff @(posedge clk_i) begin
    if (query_acc) begin
      long_sum_q  <= '0;
      short_sum_q <= '0;
      long_cnt_q  <= '0;
      short_cnt_q <= '0;
      long_max_q  <= '0;
    end else if (s2_vld_q && s2_long_q) begin
      long_sum_q <= long_sum_q + SUM_W'(s2_dur_q);
      long_cnt_q <= long_cnt_q + CNT_W'(1);
      if (s2_dur_q > long_max_q) begin
        long_max_q <= s2_dur_q;
      end
      if (s2_short_q) begin
        short_sum_q <= short_sum_q + SUM_W'(s2_dur_q);
        short_cnt_q <= short_cnt_q + CNT_W'(1);
      end
    end
  end

  logic scan_done;
  assign scan_done = (rd_idx_q == fill_q) && !rd_vld_q && !s2_vld_q;

  // shared divider: long mean first, then short mean
  logic             div_start, div_done;
  logic [SUM_W-1:0] div_quo;

  assign div_start = ((state_q == ST_SCAN) && scan_done) ||
                     ((state_q == ST_DIV_LONG) && div_done);

  wls_div #(
    .N(SUM_W),
    .D(CNT_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i((state_q == ST_DIV_LONG) ? short_sum_q : long_sum_q),
    .divisor_i ((state_q == ST_DIV_LONG) ? short_cnt_q : long_cnt_q),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  logic [wls_pkg::DUR_W-1:0] long_avg_q, short_avg_q;

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DIV_LONG) && div_done) begin
      long_avg_q <= div_quo[wls_pkg::DUR_W-1:0];
    end
    if ((state_q == ST_DIV_SHORT) && div_done) begin
      short_avg_q <= div_quo[wls_pkg::DUR_W-1:0];
    end
  end

  logic [wls_pkg::OUT_DATA_W-1:0] m_tdata_q;
  logic [wls_pkg::OUT_USER_W-1:0] m_tuser_q;
  logic                           m_tvalid_q;
  logic                           long_any, short_any;

  assign long_any  = (long_cnt_q != '0);
  assign short_any = (short_cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      m_tvalid_q <= 1'b0;
      m_tdata_q  <= '0;
      m_tuser_q  <= '0;
    end else begin
      if (m_tvalid_q && m_axis_tready_i && (state_q != ST_RESULT)) begin
        m_tvalid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (query_acc) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            state_q <= ST_DIV_LONG;
          end
        end
        ST_DIV_LONG: begin
          if (div_done) begin
            state_q <= ST_DIV_SHORT;
          end
        end
        ST_DIV_SHORT: begin
          if (div_done) begin
            state_q <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (!m_tvalid_q || m_axis_tready_i) begin
            m_tvalid_q <= 1'b1;
            m_tuser_q  <= {long_any, short_any};
            m_tdata_q  <= {long_any ? long_max_q : '0,
                           long_any ? long_avg_q : '0,
                           short_any ? short_avg_q : '0};
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;
  assign m_axis_tuser_o  = m_tuser_q;

endmodule

// ===== rtl/core/wls_checker.sv =====
module wls_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic [0:0]                     s_axis_tuser_i,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic [wls_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic [wls_pkg::OUT_USER_W-1:0] m_axis_tuser_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i
);

  // a query holds off further requests while it runs
  a_query_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i[0] == wls_pkg::REQ_QUERY))
      |=> !s_axis_tready_o)
    else $error("request taken right after a query");

  // short window is a subset of the long window; empty long window gives zeros
  a_empty_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[1]) |-> (!m_axis_tuser_o[0] && (m_axis_tdata_o == '0)))
    else $error("nonzero result with empty long window");

  a_mean_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1])
      |-> (m_axis_tdata_o[63:32] <= m_axis_tdata_o[95:64]))
    else $error("long mean above long maximum");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i)
      |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("stalled result changed");

endmodule

bind windowed_latency_statistics_core wls_checker u_wls_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tuser_i (s_axis_tuser_i),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i)
);

// ===== verif/window_stats_checker.sv =====
`timescale 1ns / 1ps

// Watches the request, result and window-register ports, keeps its own copy of the
// sample ring, and predicts the statistics of each query at the time it is accepted.
module window_stats_checker
  import wls_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 2048
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request: [63:0] sample_time, [95:64] sample_duration, [159:96] query_time
  input  logic [IN_DATA_W-1:0]  req_tdata_i,
  // request: [0] req_type
  input  logic [0:0]            req_tuser_i,
  input  logic                  req_tvalid_i,
  input  logic                  req_tready_i,
  // result: [31:0] short_average_us, [63:32] long_average_us, [95:64] long_maximum_us
  input  logic [OUT_DATA_W-1:0] res_tdata_i,
  // result: [0] short_valid, [1] long_valid
  input  logic [OUT_USER_W-1:0] res_tuser_i,
  input  logic                  res_tvalid_i,
  input  logic                  res_tready_i,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [WIN_W-1:0]      cfg_wdata_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);

  typedef struct packed {
    logic             short_valid;
    logic [DUR_W-1:0] short_average;
    logic             long_valid;
    logic [DUR_W-1:0] long_average;
    logic [DUR_W-1:0] long_maximum;
  } window_stats_t;

  logic              slot_filled [RING_DEPTH];
  logic [TIME_W-1:0] slot_time   [RING_DEPTH];
  logic [DUR_W-1:0]  slot_dur    [RING_DEPTH];
  int unsigned       next_slot;
  logic [WIN_W-1:0]  long_window;
  logic [WIN_W-1:0]  short_window;
  window_stats_t     stats_q [$];
  window_stats_t     oldest;

  function automatic window_stats_t window_stats(input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] age;
    logic [63:0]       long_sum;
    logic [63:0]       short_sum;
    logic [63:0]       long_n;
    logic [63:0]       short_n;
    logic [DUR_W-1:0]  long_max;
    window_stats_t     r;
    long_sum  = '0;
    short_sum = '0;
    long_n    = '0;
    short_n   = '0;
    long_max  = '0;
    r         = '0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      // future samples never count
      if (!slot_filled[i] || slot_time[i] > now) continue;
      age = now - slot_time[i];
      if (age > TIME_W'(long_window)) continue;
      long_sum += slot_dur[i];
      long_n++;
      if (slot_dur[i] > long_max) long_max = slot_dur[i];
      // short window only ever counts long window samples
      if (age <= TIME_W'(short_window)) begin
        short_sum += slot_dur[i];
        short_n++;
      end
    end
    r.long_valid  = (long_n != 0);
    r.short_valid = (short_n != 0);
    if (long_n != 0) begin
      r.long_average = DUR_W'(long_sum / long_n);
      r.long_maximum = long_max;
    end
    if (short_n != 0) begin
      r.short_average = DUR_W'(short_sum / short_n);
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [DUR_W-1:0] want,
                             input logic [DUR_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RING_DEPTH; i++) slot_filled[i] = 1'b0;
      next_slot    = 0;
      long_window  = LONG_WINDOW_RST;
      short_window = SHORT_WINDOW_RST;
      stats_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_LONG_WINDOW) long_window = cfg_wdata_i;
        else short_window = cfg_wdata_i;
      end
      // results first: a result can never belong to a query taken on the same edge
      if (res_tvalid_i && res_tready_i) begin
        if (stats_q.size() == 0) begin
          $display("%0t: result with no query outstanding: tuser %b tdata %h",
                   $time, res_tuser_i, res_tdata_i);
          fail_count_o++;
        end else begin
          oldest = stats_q.pop_front();
          check_field("short_valid", DUR_W'(oldest.short_valid), DUR_W'(res_tuser_i[0]));
          check_field("long_valid", DUR_W'(oldest.long_valid), DUR_W'(res_tuser_i[1]));
          check_field("short_average_us", oldest.short_average, res_tdata_i[31:0]);
          check_field("long_average_us", oldest.long_average, res_tdata_i[63:32]);
          check_field("long_maximum_us", oldest.long_maximum, res_tdata_i[95:64]);
        end
      end
      if (req_tvalid_i && req_tready_i) begin
        if (req_tuser_i[0] == REQ_ADD) begin
          slot_time[next_slot]   = req_tdata_i[TIME_W-1:0];
          slot_dur[next_slot]    = req_tdata_i[TIME_W +: DUR_W];
          slot_filled[next_slot] = 1'b1;
          next_slot              = (next_slot + 1) % RING_DEPTH;
        end else begin
          stats_q.push_back(window_stats(req_tdata_i[TIME_W+DUR_W +: TIME_W]));
        end
      end
      pending_o = stats_q.size();
    end
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import wls_pkg::*;

  localparam int unsigned RING_DEPTH   = 2048;
  localparam int unsigned QUERY_CYCLES = RING_DEPTH + 2 * ($clog2(RING_DEPTH) + 33) + 6;
  localparam int unsigned DRAIN_CYCLES = 2 * QUERY_CYCLES;
  localparam int unsigned CFG_SETTLE   = 16;
  localparam int unsigned STALL_LIMIT  = 10 * (QUERY_CYCLES + 100);

  logic                  clk;
  logic                  rst_n;
  logic [IN_DATA_W-1:0]  req_tdata;
  logic [0:0]            req_tuser;
  logic                  req_tvalid;
  logic                  req_tready;
  logic [OUT_DATA_W-1:0] res_tdata;
  logic [OUT_USER_W-1:0] res_tuser;
  logic                  res_tvalid;
  logic                  res_tready = 1'b0;
  logic                  cfg_we;
  logic                  cfg_index;
  logic [WIN_W-1:0]      cfg_wdata;
  int unsigned           fail_count;
  int unsigned           pending;

  // sender pacing, receiver stall pattern and watchdog
  int unsigned           burst_left = 0;
  int unsigned           ready_mode = 0;
  int unsigned           ready_left = 0;
  int unsigned           idle_cycles = 0;

  // stimulus time base and the window settings it aims at
  logic [TIME_W-1:0]     clock_now;
  logic [WIN_W-1:0]      win_long;
  logic [WIN_W-1:0]      win_short;

  windowed_latency_statistics_core #(
    .RING_DEPTH(RING_DEPTH)
  ) uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tdata_i (req_tdata),
    .s_axis_tuser_i (req_tuser),
    .s_axis_tvalid_i(req_tvalid),
    .s_axis_tready_o(req_tready),
    .m_axis_tdata_o (res_tdata),
    .m_axis_tuser_o (res_tuser),
    .m_axis_tvalid_o(res_tvalid),
    .m_axis_tready_i(res_tready),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata)
  );

  window_stats_checker #(
    .RING_DEPTH(RING_DEPTH)
  ) checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_tdata_i (req_tdata),
    .req_tuser_i (req_tuser),
    .req_tvalid_i(req_tvalid),
    .req_tready_i(req_tready),
    .res_tdata_i (res_tdata),
    .res_tuser_i (res_tuser),
    .res_tvalid_i(res_tvalid),
    .res_tready_i(res_tready),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver: runs of always ready, coin flips, rare ready, or a hard stall
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_left = $urandom_range(1, 40);
    end
    ready_left--;
    case (ready_mode)
      0: res_tready <= 1'b1;
      1: res_tready <= 1'($urandom_range(0, 1));
      2: res_tready <= ($urandom_range(0, 5) == 0);
      default: res_tready <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_tvalid && req_tready) || (res_tvalid && res_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // a window edge give or take two, never below zero
  function automatic logic [63:0] near_edge(input logic [WIN_W-1:0] w);
    logic [63:0] t;
    t = 64'(w) + $urandom_range(0, 4);
    return (t < 2) ? 64'd0 : t - 2;
  endfunction

  function automatic logic [63:0] pick_age();
    logic [63:0] span;
    span = ((win_long > win_short) ? 64'(win_long) : 64'(win_short)) * 2 + 5;
    case ($urandom_range(0, 5))
      0: return 64'($urandom_range(0, 3));
      1: return near_edge(win_long);
      2: return near_edge(win_short);
      3: return rand64() % span;
      default: return rand64() % (64'(win_long) + 1);
    endcase
  endfunction

  function automatic logic [DUR_W-1:0] pick_duration();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 32'hFFFF_FF00 | $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  // count down the burst; at its end, drop valid for a random gap, then pick the next burst length
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      req_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(0, 12);
    end
  endtask

  task automatic send_request(input logic kind, input logic [TIME_W-1:0] stime,
                              input logic [DUR_W-1:0] dur, input logic [TIME_W-1:0] qtime);
    req_tuser  <= kind;
    req_tdata  <= {qtime, dur, stime};
    req_tvalid <= 1'b1;
    @(posedge clk);
    while (!req_tready) @(posedge clk);
    @(negedge clk);
    pace();
  endtask

  task automatic add_sample(input logic [TIME_W-1:0] stime, input logic [DUR_W-1:0] dur);
    send_request(REQ_ADD, stime, dur, rand64());
  endtask

  task automatic query_stats(input logic [TIME_W-1:0] qtime);
    send_request(REQ_QUERY, rand64(), $urandom, qtime);
  endtask

  task automatic random_item();
    if ($urandom_range(0, 5) == 0) begin
      case ($urandom_range(0, 7))
        0: query_stats(rand64());
        1: query_stats(clock_now - $urandom_range(0, 3));
        default: query_stats(clock_now);
      endcase
    end else begin
      case ($urandom_range(0, 15))
        0: add_sample(rand64(), pick_duration());
        1: add_sample(clock_now + $urandom_range(1, 3), pick_duration());
        default: add_sample(clock_now - pick_age(), pick_duration());
      endcase
    end
    if ($urandom_range(0, 3) == 0) clock_now += rand64() % (64'(win_short) / 8 + 2);
  endtask

  task automatic wait_drained();
    req_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_windows(input logic [WIN_W-1:0] long_w, input logic [WIN_W-1:0] short_w);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LONG_WINDOW;
    cfg_wdata <= long_w;
    @(negedge clk);
    cfg_index <= CFG_SHORT_WINDOW;
    cfg_wdata <= short_w;
    @(negedge clk);
    cfg_we    <= 1'b0;
    win_long  = long_w;
    win_short = short_w;
  endtask

  task automatic run_phase(input logic [WIN_W-1:0] long_w, input logic [WIN_W-1:0] short_w,
                           input logic [TIME_W-1:0] start, input int unsigned count);
    wait_drained();
    repeat (CFG_SETTLE) @(negedge clk);
    set_windows(long_w, short_w);
    clock_now = start;
    repeat (count) random_item();
  endtask

  initial begin
    rst_n      = 1'b0;
    req_tvalid = 1'b0;
    req_tuser  = REQ_ADD;
    req_tdata  = '0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_LONG_WINDOW;
    cfg_wdata  = '0;
    win_long   = LONG_WINDOW_RST;
    win_short  = SHORT_WINDOW_RST;
    clock_now  = 64'd20_000_000;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset windows: empty ring, then samples right on and just past each edge
    query_stats(clock_now);
    add_sample(clock_now, '1);
    add_sample(clock_now - 64'd1_000_000, '0);
    add_sample(clock_now - 64'd1_000_001, '1);
    add_sample(clock_now - 64'd10_000_000, 32'd7);
    add_sample(clock_now - 64'd10_000_001, 32'd1000);
    add_sample(clock_now + 64'd1, 32'd5);
    add_sample('1, 32'd3);
    add_sample('0, 32'd9);
    query_stats(clock_now);
    query_stats(clock_now - 64'd1);
    query_stats('0);
    query_stats('1);
    query_stats(clock_now + 64'd1_000_000);
    query_stats(clock_now + 64'd10_000_000);
    query_stats(clock_now + 64'd10_000_001);
    repeat (55) random_item();

    run_phase(32'd1000, 32'd100, rand64(), 55);
    // zero windows hold only samples stamped exactly at the query time
    run_phase(32'd0, 32'd0, {32'd0, $urandom}, 50);
    // short wider than long
    run_phase(32'd50, 32'd500, rand64(), 50);
    run_phase('1, '1, {32'hFFFF_FFFF, $urandom}, 50);
    run_phase(32'd1, 32'd0, rand64(), 45);
    run_phase($urandom_range(1, 100000), $urandom_range(0, 100000), rand64(), 45);

    // large durations first, small ones after them
    wait_drained();
    repeat (CFG_SETTLE) @(negedge clk);
    set_windows('1, 32'h0001_0000);
    clock_now = {$urandom | 32'h1, $urandom};
    for (int k = 0; k < 32; k++) begin
      add_sample(clock_now - ((k % 2) ? $urandom_range(0, 32'h1_FFFF) : $urandom),
                 (k < 16) ? pick_duration() : $urandom_range(0, 1000));
      if (k % 8 == 7) query_stats(clock_now);
    end
    query_stats(clock_now);
    query_stats(clock_now + 64'h1_0000);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
